FILE: hw/rtl/rbu_pkg.sv
// Shared types and constants for the RGBA8 blend unit.
// Used by rbu_ctrl, rbu_lane and rgba8_blend_unit_core; depends on nothing.
package rbu_pkg;

  localparam int STAGES = 4;

  localparam logic [7:0] CHAN_FULL = 8'd255;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_STRAIGHT = 2'd0;
  localparam mode_t MODE_PREMUL   = 2'd1;
  localparam mode_t MODE_ADD      = 2'd2;
  localparam mode_t MODE_MUL      = 2'd3;

  typedef logic [2:0] lane_op_t;

  localparam lane_op_t OP_STRAIGHT = 3'd0;
  localparam lane_op_t OP_PREMUL   = 3'd1;
  localparam lane_op_t OP_ADD      = 3'd2;
  localparam lane_op_t OP_MUL      = 3'd3;
  localparam lane_op_t OP_PASS     = 3'd4;

  typedef struct packed {
    logic [STAGES-1:0] load;
    logic [STAGES-1:0] valid;
  } pipe_ctrl_t;

endpackage

FILE: hw/rtl/rbu_ctrl.sv
// Valid and stall control for the four-stage blend pipeline.
// Depends on rbu_pkg for the stage count and the control struct.
module rbu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output rbu_pkg::pipe_ctrl_t ctrl
);
  import rbu_pkg::*;

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] adv;

  // A stage takes new contents when it is empty or its successor moves on.
  always_comb begin
    adv[STAGES-1] = !valid[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (adv[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign in_ready   = adv[0];
  assign out_valid  = valid[STAGES-1];
  assign ctrl.load  = adv;
  assign ctrl.valid = valid;

endmodule

FILE: hw/rtl/rbu_lane.sv
// One channel of the blend datapath: multiply, sum, divide by 255, add and saturate.
// Depends on rbu_pkg; stepped by the control struct from rbu_ctrl.
module rbu_lane (
  input  logic                clk,
  input  rbu_pkg::pipe_ctrl_t ctrl,
  input  rbu_pkg::lane_op_t   op,
  input  logic [7:0]          s,
  input  logic [7:0]          d,
  input  logic [7:0]          a,
  output logic [7:0]          res
);
  import rbu_pkg::*;

  logic [7:0]  inv;
  logic [7:0]  mx;
  logic [7:0]  my;
  logic [7:0]  mz;
  logic [7:0]  mw;
  logic [7:0]  addend;

  logic [15:0] m1;
  logic [15:0] m2;
  logic [7:0]  add1;

  logic [16:0] p_sum;
  logic [9:0]  q_est;
  logic [16:0] p2;
  logic [9:0]  q0;
  logic [7:0]  add2;

  logic [18:0] rem;
  logic [9:0]  q3;
  logic [7:0]  add3;

  logic [10:0] total;

  always_comb begin
    inv    = CHAN_FULL - a;
    mx     = '0;
    my     = '0;
    mz     = '0;
    mw     = '0;
    addend = '0;
    unique case (op)
      OP_STRAIGHT: begin
        mx = s;
        my = a;
        mz = d;
        mw = inv;
      end
      OP_PREMUL: begin
        mz     = d;
        mw     = inv;
        addend = s;
      end
      OP_ADD: begin
        mx     = s;
        my     = a;
        addend = d;
      end
      OP_MUL: begin
        mx = s;
        my = d;
        mz = d;
        mw = inv;
      end
      default: begin
        addend = d;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      m1   <= 16'(mx) * 16'(my);
      m2   <= 16'(mz) * 16'(mw);
      add1 <= addend;
    end
  end

  // The estimate is never above the true quotient and at most one below it.
  always_comb begin
    p_sum = {1'b0, m1} + {1'b0, m2};
    q_est = 10'((18'(p_sum) + 18'(p_sum >> 8)) >> 8);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      p2   <= p_sum;
      q0   <= q_est;
      add2 <= add1;
    end
  end

  assign rem = 19'(p2) + 19'(q0) - 19'({q0, 8'd0});

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      q3   <= q0 + 10'(rem >= 19'd255);
      add3 <= add2;
    end
  end

  assign total = 11'(q3) + 11'(add3);

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      res <= (total > 11'(CHAN_FULL)) ? CHAN_FULL : total[7:0];
    end
  end

endmodule

FILE: hw/rtl/rgba8_blend_unit_core.sv
// Top level of the RGBA8 blend unit: mode register, pipeline control and four lanes.
// Depends on rbu_pkg, rbu_ctrl and rbu_lane.
//
// The unit blends one source and one destination RGBA8 pixel per beat and accepts a
// new beat every clock; each result passes through the four register stages
// (multiply, sum and quotient estimate, quotient correction, add and saturate), the
// first of which captures the beat. A stalled output holds the pipeline without losing
// beats, and bubbles are squeezed out. The blend mode is sampled as a beat enters, so
// it should be written only while the unit is empty.
module rgba8_blend_unit_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [1:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] src_red,
  input  logic [7:0] src_green,
  input  logic [7:0] src_blue,
  input  logic [7:0] src_alpha,
  input  logic [7:0] dst_red,
  input  logic [7:0] dst_green,
  input  logic [7:0] dst_blue,
  input  logic [7:0] dst_alpha,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);
  import rbu_pkg::*;

  mode_t      blend_mode;
  lane_op_t   color_op;
  lane_op_t   alpha_op;
  pipe_ctrl_t ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_STRAIGHT;
    end else if (cfg_write_en) begin
      blend_mode <= cfg_write_data;
    end
  end

  always_comb begin
    unique case (blend_mode)
      MODE_STRAIGHT: begin
        color_op = OP_STRAIGHT;
        alpha_op = OP_PREMUL;
      end
      MODE_PREMUL: begin
        color_op = OP_PREMUL;
        alpha_op = OP_PREMUL;
      end
      MODE_ADD: begin
        color_op = OP_ADD;
        alpha_op = OP_PASS;
      end
      MODE_MUL: begin
        color_op = OP_MUL;
        alpha_op = OP_PASS;
      end
      default: begin
        color_op = OP_STRAIGHT;
        alpha_op = OP_PREMUL;
      end
    endcase
  end

  rbu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  rbu_lane u_lane_red (
    .clk  (clk),
    .ctrl (ctrl),
    .op   (color_op),
    .s    (src_red),
    .d    (dst_red),
    .a    (src_alpha),
    .res  (out_red)
  );

  rbu_lane u_lane_green (
    .clk  (clk),
    .ctrl (ctrl),
    .op   (color_op),
    .s    (src_green),
    .d    (dst_green),
    .a    (src_alpha),
    .res  (out_green)
  );

  rbu_lane u_lane_blue (
    .clk  (clk),
    .ctrl (ctrl),
    .op   (color_op),
    .s    (src_blue),
    .d    (dst_blue),
    .a    (src_alpha),
    .res  (out_blue)
  );

  rbu_lane u_lane_alpha (
    .clk  (clk),
    .ctrl (ctrl),
    .op   (alpha_op),
    .s    (src_alpha),
    .d    (dst_alpha),
    .a    (src_alpha),
    .res  (out_alpha)
  );

`ifndef NO_ASSERTIONS
  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> ((&ctrl.valid) && !out_ready))
    else $error("input stalled while the pipeline had room");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> ctrl.valid[0])
    else $error("accepted beat did not enter the first stage");

  a_beat_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(ctrl.valid) == $countones($past(ctrl.valid))
      + (($past(in_valid) && $past(in_ready)) ? 1 : 0)
      - (($past(out_valid) && $past(out_ready)) ? 1 : 0)))
    else $error("beat lost or duplicated inside the pipeline");

  a_held_output: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable({out_red, out_green, out_blue, out_alpha})))
    else $error("output beat changed while it was stalled");
`endif

endmodule

FILE: dv/rgba8_blend_unit_core_tb.sv
// Self-checking testbench for rgba8_blend_unit_core: directed and random pixel blends
// in every blend mode, with bursty input and a stalling output side.
// Depends on rbu_pkg and the rgba8_blend_unit_core RTL.
`timescale 1ns / 100ps

module rgba8_blend_unit_core_tb;
  import rbu_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PIPE_SLACK = STAGES + 4;
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 225;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct {
    mode_t mode;
    rgba_t src;
    rgba_t dst;
    bit    known;
    rgba_t want;
  } blend_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_write_en = 1'b0;
  logic [1:0] cfg_write_data = MODE_STRAIGHT;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] src_red = '0;
  logic [7:0] src_green = '0;
  logic [7:0] src_blue = '0;
  logic [7:0] src_alpha = '0;
  logic [7:0] dst_red = '0;
  logic [7:0] dst_green = '0;
  logic [7:0] dst_blue = '0;
  logic [7:0] dst_alpha = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  bit    pin_known = 1'b0;
  rgba_t pin_want = '0;

  mode_t      mode_now = MODE_STRAIGHT;
  rgba_t      pending_pixels[$];
  blend_row_t dir_rows[$];
  string      chan_names[4] = '{"alpha", "blue", "green", "red"};

  int err_count = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int mode_writes = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int ready_style = 0;
  int ready_left = 0;
  int ready_tick = 0;

  rgba8_blend_unit_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .src_red       (src_red),
    .src_green     (src_green),
    .src_blue      (src_blue),
    .src_alpha     (src_alpha),
    .dst_red       (dst_red),
    .dst_green     (dst_green),
    .dst_blue      (dst_blue),
    .dst_alpha     (dst_alpha),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] blend_chan(mode_t m, logic [7:0] s, logic [7:0] d,
                                            logic [7:0] a);
    int unsigned full;
    int unsigned inv;
    int unsigned mix;
    full = CHAN_FULL;
    inv = full - a;
    case (m)
      MODE_STRAIGHT: mix = (s * a + d * inv) / full;
      MODE_PREMUL:   mix = s + (d * inv) / full;
      MODE_ADD:      mix = d + (s * a) / full;
      default:       mix = (s * d + d * inv) / full;
    endcase
    return (mix > full) ? CHAN_FULL : mix[7:0];
  endfunction

  function automatic rgba_t blend_pixel(mode_t m, rgba_t src, rgba_t dst);
    rgba_t res;
    res.red   = blend_chan(m, src.red, dst.red, src.alpha);
    res.green = blend_chan(m, src.green, dst.green, src.alpha);
    res.blue  = blend_chan(m, src.blue, dst.blue, src.alpha);
    if (m == MODE_STRAIGHT || m == MODE_PREMUL) begin
      // Coverage alpha follows the premultiplied form with the source alpha as color.
      res.alpha = blend_chan(MODE_PREMUL, src.alpha, dst.alpha, src.alpha);
    end else begin
      res.alpha = dst.alpha;
    end
    return res;
  endfunction

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return CHAN_FULL;
      2:       return 8'($urandom_range(1, 3));
      3:       return 8'($urandom_range(252, 254));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      pending_pixels.push_back(pin_known ? pin_want :
        blend_pixel(mode_now, {src_red, src_green, src_blue, src_alpha},
                    {dst_red, dst_green, dst_blue, dst_alpha}));
    end
  end

  always @(posedge clk) begin
    rgba_t got;
    rgba_t want;
    if (!rst && out_valid && out_ready) begin
      got = {out_red, out_green, out_blue, out_alpha};
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result %h with no pixel outstanding", $time, got);
        err_count++;
      end else begin
        want = pending_pixels.pop_front();
        results_checked++;
        for (int k = 0; k < 4; k++) begin
          if (got[8*k +: 8] !== want[8*k +: 8]) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan_names[k],
                     want[8*k +: 8], got[8*k +: 8]);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_style <= $urandom_range(0, 2);
      ready_left <= $urandom_range(50, 300);
    end else begin
      ready_left <= ready_left - 1;
    end
    ready_tick <= (ready_tick == 4) ? 0 : ready_tick + 1;
    case (ready_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (ready_tick < 3);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without a beat", idle_cycles);
      $display("rgba8_blend_unit_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input rgba_t src, input rgba_t dst, input bit known,
                           input rgba_t want);
    in_valid  <= 1'b1;
    src_red   <= src.red;
    src_green <= src.green;
    src_blue  <= src.blue;
    src_alpha <= src.alpha;
    dst_red   <= dst.red;
    dst_green <= dst.green;
    dst_blue  <= dst.blue;
    dst_alpha <= dst.alpha;
    pin_known <= known;
    pin_want  <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic settle_and_set_mode(input mode_t m);
    in_valid <= 1'b0;
    wait_drained();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= m;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    mode_now = m;
    mode_writes++;
  endtask

  initial begin
    mode_t phase_order[4];
    mode_t m;
    rgba_t src;
    rgba_t dst;

    phase_order = '{MODE_MUL, MODE_STRAIGHT, MODE_ADD, MODE_PREMUL};

    // Rows are 32'hRRGGBBAA; the first rows run on the mode left by reset.
    dir_rows.push_back('{MODE_STRAIGHT, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000});
    dir_rows.push_back('{MODE_STRAIGHT, 32'h0CC8FFFF, 32'h6300FF11, 1'b1, 32'h0CC8FFFF});
    dir_rows.push_back('{MODE_STRAIGHT, 32'hFFFFFF00, 32'h0180FE4D, 1'b1, 32'h0180FE4D});
    dir_rows.push_back('{MODE_STRAIGHT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF});
    dir_rows.push_back('{MODE_STRAIGHT, 32'h8040C07F, 32'h20E01090, 1'b0, 32'h0});
    dir_rows.push_back('{MODE_PREMUL,   32'hFFFFFF00, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF});
    dir_rows.push_back('{MODE_PREMUL,   32'h030405FF, 32'hAABBCCDD, 1'b1, 32'h030405FF});
    dir_rows.push_back('{MODE_PREMUL,   32'h00000000, 32'h00000000, 1'b1, 32'h00000000});
    dir_rows.push_back('{MODE_PREMUL,   32'h90105040, 32'hC0F008A0, 1'b0, 32'h0});
    dir_rows.push_back('{MODE_ADD,      32'hFFFFFFFF, 32'hFFFFFF09, 1'b1, 32'hFFFFFF09});
    dir_rows.push_back('{MODE_ADD,      32'hC8643200, 32'h070809C8, 1'b1, 32'h070809C8});
    dir_rows.push_back('{MODE_ADD,      32'h7F8001C0, 32'hA090FE33, 1'b0, 32'h0});
    dir_rows.push_back('{MODE_ADD,      32'h01010101, 32'hFEFEFEFE, 1'b0, 32'h0});
    dir_rows.push_back('{MODE_MUL,      32'hFFFFFF00, 32'hFFFFFF5A, 1'b1, 32'hFFFFFF5A});
    dir_rows.push_back('{MODE_MUL,      32'h000000FF, 32'hFF800142, 1'b1, 32'h00000042});
    dir_rows.push_back('{MODE_MUL,      32'hFFFFFFFF, 32'h0A141E28, 1'b1, 32'h0A141E28});
    dir_rows.push_back('{MODE_MUL,      32'h55AA3366, 32'h77EE9911, 1'b0, 32'h0});
    dir_rows.push_back('{MODE_STRAIGHT, 32'hAA55AA55, 32'h55AA55AA, 1'b0, 32'h0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != mode_now) settle_and_set_mode(dir_rows[i].mode);
      send_beat(dir_rows[i].src, dir_rows[i].dst, dir_rows[i].known, dir_rows[i].want);
      pace_sender();
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      m = (phase < 4) ? phase_order[phase] : mode_t'($urandom_range(0, 3));
      settle_and_set_mode(m);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        src = {pick_chan(), pick_chan(), pick_chan(), pick_chan()};
        dst = {pick_chan(), pick_chan(), pick_chan(), pick_chan()};
        send_beat(src, dst, 1'b0, '0);
        pace_sender();
      end
    end

    in_valid <= 1'b0;
    wait_drained();

    $display("Blended %0d pixels over %0d mode writes covering all four blend modes;",
             beats_sent, mode_writes);
    $display("%0d results were compared channel by channel.", results_checked);
    if (err_count == 0) begin
      $display("rgba8_blend_unit_core verification clean");
    end else begin
      $display("rgba8_blend_unit_core verification failed");
    end
    $finish;
  end

endmodule
